// ===== src/blr_pkg.sv =====
// blr_pkg: shared types and constants for the line rasterizer
// holds the command, pixel and queue entry structs and the walker state enum
// no dependencies
`default_nettype none

package blr_pkg;

    // width of every coordinate field on the ports
    localparam int COORD_W = 6;

    // depth of the command queue between classifier and walker
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // one line command as it arrives
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_line_in;

    // one pixel as it leaves
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } t_pixel_out;

    // classified line, major coordinate rising from maj0
    typedef struct packed {
        logic [COORD_W-1:0] maj0;
        logic [COORD_W-1:0] min0;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
        logic               min_neg;
        logic               y_major;
    } t_line_cmd;

    // walker sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_walk_state;

endpackage : blr_pkg

`default_nettype wire

// ===== src/blr_front.sv =====
// blr_front: classifies a line command into major axis, direction and deltas
// depends on blr_pkg; feeds blr_cmdq, drops zero-length lines
`default_nettype none

module blr_front #(
    parameter int COORD_BITS = 6
) (
    input  wire                 i_push,
    input  blr_pkg::t_line_in   i_line,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output blr_pkg::t_line_cmd  o_q_cmd
);

    import blr_pkg::*;

    localparam int CB = COORD_BITS;

    logic [CB-1:0] x0, y0, x1, y1;
    logic [CB:0]   dx, dy, ndx, ndy;
    logic [CB-1:0] adx, ady;
    logic          x_major, swap;
    logic [CB-1:0] maj_s, maj_e, min_s, min_e;
    logic [CB-1:0] maj0, min0, min1, dmaj, dmin;

    // coordinates wrap to the window
    assign x0 = i_line.start_x[CB-1:0];
    assign y0 = i_line.start_y[CB-1:0];
    assign x1 = i_line.end_x[CB-1:0];
    assign y1 = i_line.end_y[CB-1:0];

    // absolute deltas
    assign dx  = {1'b0, x1} - {1'b0, x0};
    assign dy  = {1'b0, y1} - {1'b0, y0};
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
    assign ady = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];

    // major axis, y wins a tie
    assign x_major = (ady < adx);
    assign maj_s   = x_major ? x0 : y0;
    assign maj_e   = x_major ? x1 : y1;
    assign min_s   = x_major ? y0 : x0;
    assign min_e   = x_major ? y1 : x1;

    // order endpoints so the major coordinate rises
    assign swap = (maj_s > maj_e);
    assign maj0 = swap ? maj_e : maj_s;
    assign min0 = swap ? min_e : min_s;
    assign min1 = swap ? min_s : min_e;
    assign dmaj = x_major ? adx : ady;
    assign dmin = x_major ? ady : adx;

    // classified command
    always_comb begin
        o_q_cmd.maj0    = COORD_W'(maj0);
        o_q_cmd.min0    = COORD_W'(min0);
        o_q_cmd.dmaj    = COORD_W'(dmaj);
        o_q_cmd.dmin    = COORD_W'(dmin);
        o_q_cmd.min_neg = (min1 < min0);
        o_q_cmd.y_major = ~x_major;
    end

    // zero-length lines are taken but never queued
    assign o_q_push = i_push && !i_q_full && (dmaj != '0);

endmodule : blr_front

`default_nettype wire

// ===== src/blr_cmdq.sv =====
// blr_cmdq: small fifo of classified line commands
// depends on blr_pkg; sits between blr_front and blr_walk
`default_nettype none

module blr_cmdq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  blr_pkg::t_line_cmd  i_cmd,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output blr_pkg::t_line_cmd  o_cmd
);

    import blr_pkg::*;

    t_line_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CMDQ_CNT_W-1:0]   r_count;
    logic                    do_push, do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("command queue over its depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full command queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("command queue count did not rise on push");
`endif

endmodule : blr_cmdq

`default_nettype wire

// ===== src/blr_walk.sv =====
// blr_walk: steps a queued line by error term a pixel per unstalled cycle
// depends on blr_pkg; pops blr_cmdq and holds the pixel output register
`default_nettype none

module blr_walk #(
    parameter int COORD_BITS = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  blr_pkg::t_line_cmd  i_q_cmd,
    output logic                o_q_pop,
    output logic                o_empty,
    input  wire                 i_pop,
    output blr_pkg::t_pixel_out o_pixel
);

    import blr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 3;

    t_walk_state            r_state, n_state;
    logic [CB-1:0]          r_a, n_a, r_b, n_b, r_left, n_left;
    logic signed [EW-1:0]   r_err, n_err, r_inc_a, n_inc_a, r_inc_b, n_inc_b;
    logic                   r_min_neg, n_min_neg, r_y_major, n_y_major;
    logic                   r_out_valid, n_out_valid;
    t_pixel_out             r_out, n_out;

    logic                   advance, load, emit, last;
    logic signed [EW-1:0]   dmin_e, dmaj_e;

    assign advance = !r_out_valid || i_pop;
    assign last    = (r_left == CB'(1));
    assign dmin_e  = EW'(i_q_cmd.dmin[CB-1:0]);
    assign dmaj_e  = EW'(i_q_cmd.dmaj[CB-1:0]);

    // sequencer, stepping and output register next values
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_left      = r_left;
        n_err       = r_err;
        n_inc_a     = r_inc_a;
        n_inc_b     = r_inc_b;
        n_min_neg   = r_min_neg;
        n_y_major   = r_y_major;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        load        = 1'b0;
        emit        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    load    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    emit = 1'b1;
                    if (last) begin
                        if (!i_q_empty) begin
                            load = 1'b1;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // current pixel into the output register
        if (emit) begin
            n_out.pixel_x    = COORD_W'(r_y_major ? r_b : r_a);
            n_out.pixel_y    = COORD_W'(r_y_major ? r_a : r_b);
            n_out.last_pixel = last;
            n_out_valid      = 1'b1;
        end

        // one Bresenham step
        if (emit) begin
            n_a    = r_a + 1'b1;
            n_left = r_left - 1'b1;
            if (r_err > 0) begin
                n_b   = r_min_neg ? r_b - 1'b1 : r_b + 1'b1;
                n_err = r_err + r_inc_b;
            end else begin
                n_err = r_err + r_inc_a;
            end
        end

        // start a new line
        if (load) begin
            n_a       = i_q_cmd.maj0[CB-1:0];
            n_b       = i_q_cmd.min0[CB-1:0];
            n_left    = i_q_cmd.dmaj[CB-1:0];
            n_err     = (dmin_e <<< 1) - dmaj_e;
            n_inc_a   = dmin_e <<< 1;
            n_inc_b   = (dmin_e - dmaj_e) <<< 1;
            n_min_neg = i_q_cmd.min_neg;
            n_y_major = i_q_cmd.y_major;
        end
    end

    assign o_q_pop = load;
    assign o_empty = !r_out_valid;
    assign o_pixel = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_left    <= n_left;
        r_err     <= n_err;
        r_inc_a   <= n_inc_a;
        r_inc_b   <= n_inc_b;
        r_min_neg <= n_min_neg;
        r_y_major <= n_y_major;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left != '0))
        else $error("walker running with no pixels left");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("walker popped an empty command queue");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last && i_q_empty) |=> (r_state == ST_IDLE))
        else $error("walker did not stop after last pixel");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted pixel not held in output register");
`endif

endmodule : blr_walk

`default_nettype wire

// ===== src/bresenham_line_rasterizer_top.sv =====
// bresenham_line_rasterizer_top: line command in, pixel beats out
// depends on blr_pkg, blr_front, blr_cmdq and blr_walk
`default_nettype none

// A line command (two endpoints) is taken whenever o_full is low; the
// classifier picks the major axis (y on a tie), orders the endpoints so the
// major coordinate rises and queues the command in a two-entry queue. The
// walker pops a command and produces one pixel per cycle, |major delta|
// pixels per line, the far endpoint left out and the final pixel flagged by
// last_pixel; a zero-length line is accepted and yields no beat. A line has
// at most 63 pixels. The walker takes a load step when it starts from idle,
// so the first beat of a line taken by an idle block passes through the
// queue, the walker load and the output register. A queued line is loaded
// in the cycle of the previous line's last pixel, so its beats follow with
// no gap, and the walker stalls only while the output register holds a beat
// that has not been popped. Coordinates wrap to the low COORD_BITS bits.

module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = 6
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  blr_pkg::t_line_in   i_cmd,
    output logic                o_empty,
    input  wire                 i_pop,
    output blr_pkg::t_pixel_out o_pixel
);

    import blr_pkg::*;

    logic      q_push, q_full, q_pop, q_empty;
    t_line_cmd q_wr_cmd, q_rd_cmd;

    assign o_full = q_full;

    // classify incoming lines
    blr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_push   (i_push),
        .i_line   (i_cmd),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_wr_cmd)
    );

    // decoupling queue
    blr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_rd_cmd)
    );

    // pixel walker and output register
    blr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_rd_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_pixel   (o_pixel)
    );

endmodule : bresenham_line_rasterizer_top

`default_nettype wire
